/* sv/lsbc_pkg.sv */
// Shared types and constants for the laser spot bounding box center unit.
// No dependencies; every other file imports this package.
`default_nettype none
package lsbc_pkg;

	localparam int FRAME_ROWS = 240;
	localparam int FRAME_COLS = 320;

	localparam int BYTE_W  = 8;
	localparam int PIX_W   = 16;
	localparam int ROW_W   = 8;
	localparam int COL_W   = 9;
	localparam int CFG_IDX_W = 2;
	localparam int TDATA_W = 40;

	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(FRAME_ROWS - 1);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(FRAME_COLS - 1);

	localparam logic [PIX_W-1:0] TARGET_RESET = 16'd63488;
	localparam logic [PIX_W-1:0] TOL_RESET    = 16'd2500;
	localparam logic [PIX_W-1:0] PIX_WHITE    = 16'hFFFF;
	localparam logic [PIX_W-1:0] PIX_BLACK    = 16'h0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_COLOR    = 2'd0,
		REG_COLOR_TOLERANCE = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last;
		logic             found;
		logic [ROW_W-1:0] center_row;
		logic [COL_W-1:0] center_col;
	} lsbc_res_t;

endpackage
`default_nettype wire

/* sv/lsbc_cfg.sv */
// Configuration registers: target color and tolerance of the match window.
// Depends on lsbc_pkg.
`default_nettype none
module lsbc_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [lsbc_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [lsbc_pkg::PIX_W-1:0]    wr_data,
	output logic      [lsbc_pkg::PIX_W-1:0]    target_color,
	output logic      [lsbc_pkg::PIX_W-1:0]    color_tolerance
);
	import lsbc_pkg::*;

	logic [PIX_W-1:0] target_q;
	logic [PIX_W-1:0] tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
			tol_q    <= TOL_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_TARGET_COLOR:    target_q <= wr_data;
				REG_COLOR_TOLERANCE: tol_q    <= wr_data;
				default: ;
			endcase
		end
	end

	assign target_color    = target_q;
	assign color_tolerance = tol_q;

endmodule
`default_nettype wire

/* sv/lsbc_track.sv */
// Byte pairing, window match, raster counters and bounding box tracking.
// Depends on lsbc_pkg.
`default_nettype none
module lsbc_track (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic                       start,
	input  wire logic [lsbc_pkg::BYTE_W-1:0] data_byte,
	input  wire logic [lsbc_pkg::PIX_W-1:0]  target_color,
	input  wire logic [lsbc_pkg::PIX_W-1:0]  color_tolerance,
	output logic                            emit,
	output lsbc_pkg::lsbc_res_t             res
);
	import lsbc_pkg::*;

	logic             phase_q;
	logic [BYTE_W-1:0] high_q;
	logic [ROW_W-1:0] row_q, rmin_q, rmax_q;
	logic [COL_W-1:0] col_q, cmin_q, cmax_q;
	logic             any_q;

	logic [ROW_W-1:0] row_e, rmin_e, rmax_e, rmin_n, rmax_n;
	logic [COL_W-1:0] col_e, cmin_e, cmax_e, cmin_n, cmax_n;
	logic             any_e, any_n;
	logic [PIX_W-1:0] pix;
	logic [PIX_W:0]   lo_sum, hi_sum;
	logic             hit, last;
	logic [ROW_W:0]   rsum;
	logic [COL_W:0]   csum;

	always_comb begin
		row_e  = start ? '0 : row_q;
		col_e  = start ? '0 : col_q;
		rmin_e = start ? '0 : rmin_q;
		rmax_e = start ? '0 : rmax_q;
		cmin_e = start ? '0 : cmin_q;
		cmax_e = start ? '0 : cmax_q;
		any_e  = start ? 1'b0 : any_q;
		emit   = !start && phase_q;

		pix    = {high_q, data_byte};
		lo_sum = {1'b0, pix} + {1'b0, color_tolerance};
		hi_sum = {1'b0, target_color} + {1'b0, color_tolerance};
		hit    = (lo_sum > {1'b0, target_color}) && ({1'b0, pix} < hi_sum);

		rmin_n = rmin_e;
		rmax_n = rmax_e;
		cmin_n = cmin_e;
		cmax_n = cmax_e;
		any_n  = any_e;
		if (hit) begin
			any_n = 1'b1;
			if (!any_e) begin
				rmin_n = row_e;
				rmax_n = row_e;
				cmin_n = col_e;
				cmax_n = col_e;
			end else begin
				if (row_e < rmin_e) rmin_n = row_e;
				if (row_e > rmax_e) rmax_n = row_e;
				if (col_e < cmin_e) cmin_n = col_e;
				if (col_e > cmax_e) cmax_n = col_e;
			end
		end

		last = (row_e >= ROW_LAST) && (col_e >= COL_LAST);
		rsum = {1'b0, rmin_n} + {1'b0, rmax_n};
		csum = {1'b0, cmin_n} + {1'b0, cmax_n};

		res.pixel      = hit ? PIX_WHITE : PIX_BLACK;
		res.last       = last;
		res.found      = last && any_n;
		res.center_row = res.found ? rsum[ROW_W:1] : '0;
		res.center_col = res.found ? csum[COL_W:1] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			high_q  <= '0;
			row_q   <= '0;
			col_q   <= '0;
			rmin_q  <= '0;
			rmax_q  <= '0;
			cmin_q  <= '0;
			cmax_q  <= '0;
			any_q   <= 1'b0;
		end else if (step) begin
			if (!emit) begin
				phase_q <= 1'b1;
				high_q  <= data_byte;
				row_q   <= row_e;
				col_q   <= col_e;
				rmin_q  <= rmin_e;
				rmax_q  <= rmax_e;
				cmin_q  <= cmin_e;
				cmax_q  <= cmax_e;
				any_q   <= any_e;
			end else if (last) begin
				phase_q <= 1'b0;
				high_q  <= '0;
				row_q   <= '0;
				col_q   <= '0;
				rmin_q  <= '0;
				rmax_q  <= '0;
				cmin_q  <= '0;
				cmax_q  <= '0;
				any_q   <= 1'b0;
			end else begin
				phase_q <= 1'b0;
				rmin_q  <= rmin_n;
				rmax_q  <= rmax_n;
				cmin_q  <= cmin_n;
				cmax_q  <= cmax_n;
				any_q   <= any_n;
				if (col_e >= COL_LAST) begin
					col_q <= '0;
					row_q <= row_e + ROW_W'(1);
				end else begin
					col_q <= col_e + COL_W'(1);
					row_q <= row_e;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* sv/laser_spot_bounding_box_center_unit.sv */
// A low byte's result passes through the input register and the result register; high bytes give no result.
// Throughput: one byte per cycle unless the input stage holds, set by the single input register and result register.
// The input stage holds only while the result register is full and not taken.
// Reset (arst_n low, asynchronous): stream empty, phase at high byte, counters and box
// cleared, target_color = 63488, color_tolerance = 2500.
`default_nettype none
module laser_spot_bounding_box_center_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [7:0]                      s_tdata,   // data_byte[7:0]
	input  wire logic                            s_tuser,   // start_frame
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [lsbc_pkg::TDATA_W-1:0]    m_tdata,   // pixel_out[15:0], center_row[23:16],
	                                                        // center_col[32:24], zero[39:33]
	output logic                                 m_tlast,   // frame_done
	output logic                                 m_tuser,   // spot_found
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [lsbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lsbc_pkg::PIX_W-1:0]      cfg_data
);
	import lsbc_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              start_s1;
	logic              out_free, go, emit;
	logic [PIX_W-1:0]  target_color, color_tolerance;
	lsbc_res_t         res;
	logic              m_valid_q;
	lsbc_res_t         res_q;

	assign cfg_ready = 1'b1;

	lsbc_cfg u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (cfg_valid && cfg_ready),
		.wr_index        (cfg_index),
		.wr_data         (cfg_data),
		.target_color    (target_color),
		.color_tolerance (color_tolerance)
	);

	lsbc_track u_track (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (go),
		.start           (start_s1),
		.data_byte       (byte_s1),
		.target_color    (target_color),
		.color_tolerance (color_tolerance),
		.emit            (emit),
		.res             (res)
	);

	assign out_free = !m_valid_q || m_tready;
	assign go       = valid_s1 && (!emit || out_free);
	assign s_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= go && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'b0, res_q.center_col, res_q.center_row, res_q.pixel};
	assign m_tlast  = res_q.last;
	assign m_tuser  = res_q.found;

	a_found_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.found |-> res_q.last)
		else $error("spot flag without frame end");

	a_centers_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !res_q.found |-> res_q.center_row == '0 && res_q.center_col == '0)
		else $error("nonzero center without spot");

	a_binary_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (res_q.pixel == PIX_WHITE || res_q.pixel == PIX_BLACK))
		else $error("pixel not binarized");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !go |=> valid_s1 && $stable(byte_s1) && $stable(start_s1))
		else $error("stalled input stage lost its request");

	a_no_emit_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && start_s1 |-> !emit)
		else $error("result on frame start byte");

endmodule
`default_nettype wire

/* tb/tb_laser_spot_bounding_box_center_unit.sv */
// Testbench for laser_spot_bounding_box_center_unit: streams camera bytes, predicts the
// binarized pixels and frame box centers, and checks each result against its prediction.
// Depends on lsbc_pkg and the unit's top module.
`default_nettype none
module tb_laser_spot_bounding_box_center_unit;
	import lsbc_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int DRAIN_PAD   = 8;
	localparam int CALM_FROM   = 400;
	localparam int CALM_TO     = 800;
	localparam int PIX_MAX     = 65535;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              start;
	} cam_byte_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [BYTE_W-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [TDATA_W-1:0] m_tdata;
	logic m_tlast;
	logic m_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PIX_W-1:0] cfg_data;

	cam_byte_t cam_bytes_q[$];
	lsbc_res_t pixel_results_q[$];

	int  cycles = 0;
	int  errors = 0;
	bit  sent = 1'b0;
	bit  draining = 1'b0;

	// spot tracker copy
	logic [PIX_W-1:0]  m_target;
	logic [PIX_W-1:0]  m_tol;
	logic              m_phase;
	logic [BYTE_W-1:0] m_high;
	logic [ROW_W-1:0]  m_row;
	logic [COL_W-1:0]  m_col;
	logic              m_found;
	logic [ROW_W-1:0]  m_rmin, m_rmax;
	logic [COL_W-1:0]  m_cmin, m_cmax;

	laser_spot_bounding_box_center_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void clear_box();
		m_phase = 1'b0;
		m_high  = '0;
		m_row   = '0;
		m_col   = '0;
		m_found = 1'b0;
		m_rmin  = '0;
		m_rmax  = '0;
		m_cmin  = '0;
		m_cmax  = '0;
	endfunction

	function automatic bit in_window(logic [PIX_W-1:0] p);
		int t, w, v;
		t = int'(m_target);
		w = int'(m_tol);
		v = int'(p);
		return (v > t - w) && (v < t + w);
	endfunction

	function automatic void step_spot_tracker(logic [BYTE_W-1:0] b, logic st);
		lsbc_res_t r;
		logic [PIX_W-1:0] p;
		bit hit, last;
		int s;
		if (st)
			clear_box();
		if (!m_phase) begin
			m_high  = b;
			m_phase = 1'b1;
			return;
		end
		m_phase = 1'b0;
		p = {m_high, b};
		hit = in_window(p);
		if (hit) begin
			if (!m_found) begin
				m_rmin  = m_row;
				m_rmax  = m_row;
				m_cmin  = m_col;
				m_cmax  = m_col;
				m_found = 1'b1;
			end else begin
				if (m_row < m_rmin) m_rmin = m_row;
				if (m_row > m_rmax) m_rmax = m_row;
				if (m_col < m_cmin) m_cmin = m_col;
				if (m_col > m_cmax) m_cmax = m_col;
			end
		end
		last = (m_row >= ROW_LAST) && (m_col >= COL_LAST);
		r = '0;
		r.pixel = hit ? PIX_WHITE : PIX_BLACK;
		r.last  = last;
		if (last && m_found) begin
			r.found = 1'b1;
			s = int'(m_rmin) + int'(m_rmax);
			r.center_row = ROW_W'(s >> 1);
			s = int'(m_cmin) + int'(m_cmax);
			r.center_col = COL_W'(s >> 1);
		end
		pixel_results_q.push_back(r);
		if (last) begin
			clear_box();
		end else begin
			m_col = m_col + 1'b1;
			if (m_col >= COL_W'(FRAME_COLS)) begin
				m_col = '0;
				m_row = m_row + 1'b1;
			end
		end
	endfunction

	function automatic bit take_break();
		return !(cycles >= CALM_FROM && cycles < CALM_TO) && $urandom_range(99) < 6;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endfunction

	// pick a pixel inside or outside the current window, leaning on its edges
	function automatic logic [PIX_W-1:0] pick_pixel(bit want_hit);
		int t, w, lo, hi, a, b;
		t = int'(m_target);
		w = int'(m_tol);
		lo = t - w;
		hi = t + w;
		if (want_hit) begin
			a = (lo + 1 < 0) ? 0 : lo + 1;
			b = (hi - 1 > PIX_MAX) ? PIX_MAX : hi - 1;
			if (a <= b) begin
				case ($urandom_range(3))
					0: return PIX_W'(a);
					1: return PIX_W'(b);
					default: return PIX_W'($urandom_range(b, a));
				endcase
			end
		end
		if (lo >= 0 && (hi > PIX_MAX || $urandom_range(1) == 0))
			return ($urandom_range(3) == 0) ? PIX_W'(lo) : PIX_W'($urandom_range(lo, 0));
		if (hi <= PIX_MAX)
			return ($urandom_range(3) == 0) ? PIX_W'(hi) : PIX_W'($urandom_range(PIX_MAX, hi));
		return PIX_W'($urandom_range(PIX_MAX, 0));
	endfunction

	function automatic void push_byte(logic [BYTE_W-1:0] b, logic st);
		cam_byte_t c;
		c.data  = b;
		c.start = st;
		cam_bytes_q.push_back(c);
	endfunction

	function automatic void push_pixel(logic [PIX_W-1:0] p, logic st);
		push_byte(p[15:8], st);
		push_byte(p[7:0], 1'b0);
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [PIX_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_TARGET_COLOR:    m_target = val;
			REG_COLOR_TOLERANCE: m_tol    = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_window(logic [PIX_W-1:0] t, logic [PIX_W-1:0] w);
		write_reg(REG_TARGET_COLOR, t);
		write_reg(REG_COLOR_TOLERANCE, w);
	endtask

	task automatic wait_idle();
		while (cam_bytes_q.size() != 0 || s_tvalid || pixel_results_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// request driver
	always @(negedge clk) begin
		cam_byte_t nb;
		if (arst_n) begin
			if (draining && pixel_results_q.size() == 0)
				draining = 1'b0;
			if (!s_tvalid || sent) begin
				if (cam_bytes_q.size() != 0 && !draining && !take_break()) begin
					nb = cam_bytes_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nb.data;
					s_tuser  <= nb.start;
					if ($urandom_range(2999) == 0)
						draining = 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			sent = 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			sent = 1'b1;
			step_spot_tracker(s_tdata, s_tuser);
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			m_tready <= !take_break();
	end

	// result monitor
	always @(posedge clk) begin
		lsbc_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pixel_results_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result expected none got %h", $time, m_tdata);
			end else begin
				want = pixel_results_q.pop_front();
				check_field("pixel_out", int'(want.pixel), int'(m_tdata[PIX_W-1:0]));
				check_field("frame_done", int'(want.last), int'(m_tlast));
				check_field("spot_found", int'(want.found), int'(m_tuser));
				check_field("center_row", int'(want.center_row),
					int'(m_tdata[PIX_W+ROW_W-1:PIX_W]));
				check_field("center_col", int'(want.center_col),
					int'(m_tdata[PIX_W+ROW_W+COL_W-1:PIX_W+ROW_W]));
			end
		end
	end

	initial begin
		int k, n, r;
		logic [PIX_W-1:0] ext_t[4];
		logic [PIX_W-1:0] ext_w[4];
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_TARGET_COLOR;
		cfg_data  = '0;
		m_target  = TARGET_RESET;
		m_tol     = TOL_RESET;
		clear_box();
		ext_t = '{16'd0, 16'd0, 16'hFFFF, 16'h8000};
		ext_w = '{16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset window: edges, values at the top of the pixel range, restart on a low byte
		push_pixel(TARGET_RESET, 1'b1);
		push_pixel(TARGET_RESET - TOL_RESET, 1'b0);
		push_pixel(TARGET_RESET - TOL_RESET + 1'b1, 1'b0);
		push_pixel(PIX_WHITE, 1'b0);
		push_pixel(PIX_BLACK, 1'b0);
		push_pixel(16'h7FFF, 1'b0);
		push_byte(8'h12, 1'b0);
		push_byte(8'hF8, 1'b1);
		push_byte(8'h01, 1'b0);
		push_pixel(16'h00FF, 1'b0);
		wait_idle();

		for (k = 0; k < 8; k++) begin
			if (k < 4)
				apply_window(ext_t[k], ext_w[k]);
			else if (k % 2 == 0)
				apply_window(PIX_W'($urandom_range(PIX_MAX)), PIX_W'($urandom_range(3000)));
			else
				apply_window(PIX_W'($urandom_range(PIX_MAX)), PIX_W'($urandom_range(PIX_MAX)));
			n = 0;
			while (n < 115) begin
				r = $urandom_range(99);
				if (r < 10) begin
					push_byte(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
					n++;
				end else begin
					push_pixel(pick_pixel(1'($urandom_range(1))), $urandom_range(99) < 4);
					n += 2;
				end
			end
			wait_idle();
		end

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
sv/lsbc_pkg.sv
sv/lsbc_cfg.sv
sv/lsbc_track.sv
sv/laser_spot_bounding_box_center_unit.sv
tb/tb_laser_spot_bounding_box_center_unit.sv
